### design/ram_weightless_classifier_core_defines.svh
// assertion macros for the weightless classifier core
// used by the top level only, which supplies clk and rst in scope
`ifndef RAM_WEIGHTLESS_CLASSIFIER_CORE_DEFINES_SVH
`define RAM_WEIGHTLESS_CLASSIFIER_CORE_DEFINES_SVH

// condition must never hold outside reset
`define RWC_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define RWC_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define RWC_IMPLY_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### design/rwc_pkg.sv
// shared types and constants for the weightless classifier core
// no dependencies
`timescale 1ns / 1ps

package rwc_pkg;

  localparam int PATTERN_W   = 64;
  localparam int CLASS_OUT_W = 2;
  localparam int SCORE_W     = 16;
  localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

  typedef enum logic {
    OP_TRAIN    = 1'b0,
    OP_CLASSIFY = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ISSUE
  } state_e;

  // control part of a token moving down the neuron chain
  typedef struct packed {
    logic valid;
    op_e  op;
    logic last;
    logic final_class;
  } tok_ctrl_t;

endpackage

### design/rwc_cell.sv
// one neuron cell: bit ram bank for all classes plus a stage of the score chain
// depends on rwc_pkg
`timescale 1ns / 1ps

module rwc_cell #(
  parameter int NEURON_IDX   = 0,
  parameter int CLASSES      = 4,
  parameter int ADDRESS_BITS = 8,
  parameter int SUM_W        = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          clr_en,
  input  logic [$clog2(CLASSES)+ADDRESS_BITS-1:0] clr_addr,
  input  rwc_pkg::tok_ctrl_t            in_ctrl,
  input  logic [$clog2(CLASSES)-1:0]    in_class,
  input  logic [rwc_pkg::PATTERN_W-1:0] in_pattern,
  input  logic [SUM_W-1:0]              in_sum,
  output rwc_pkg::tok_ctrl_t            out_ctrl,
  output logic [$clog2(CLASSES)-1:0]    out_class,
  output logic [rwc_pkg::PATTERN_W-1:0] out_pattern,
  output logic [SUM_W-1:0]              out_sum
);
  import rwc_pkg::*;

  localparam int CLS_W     = $clog2(CLASSES);
  localparam int RAM_AW    = CLS_W + ADDRESS_BITS;
  localparam int RAM_DEPTH = CLASSES << ADDRESS_BITS;
  localparam int BASE      = NEURON_IDX * ADDRESS_BITS;

  logic                    ram [RAM_DEPTH];
  logic [ADDRESS_BITS-1:0] grp_addr;
  logic [RAM_AW-1:0]       ram_addr;
  logic                    rd_bit;
  tok_ctrl_t               ctrl;
  logic [CLS_W-1:0]        cls;
  logic [PATTERN_W-1:0]    pat;
  logic [SUM_W-1:0]        sum;

  // group address, first group bit is the msb, bits past the pattern read 0
  for (genvar k = 0; k < ADDRESS_BITS; k++) begin : g_addr
    if (BASE + k < PATTERN_W) begin : g_in
      assign grp_addr[ADDRESS_BITS-1-k] = in_pattern[BASE+k];
    end else begin : g_out
      assign grp_addr[ADDRESS_BITS-1-k] = 1'b0;
    end
  end

  assign ram_addr = {in_class, grp_addr};

  // bit bank: clearing sweep, train write, registered read
  always_ff @(posedge clk) begin
    if (clr_en) begin
      ram[clr_addr] <= 1'b0;
    end else if (in_ctrl.valid && in_ctrl.op == OP_TRAIN) begin
      ram[ram_addr] <= 1'b1;
    end
    rd_bit <= ram[ram_addr];
  end

  // token stage
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl <= '0;
    end else begin
      ctrl <= in_ctrl;
    end
  end

  always_ff @(posedge clk) begin
    cls <= in_class;
    pat <= in_pattern;
    sum <= in_sum;
  end

  // add this neuron's hit to the running count
  assign out_ctrl    = ctrl;
  assign out_class   = cls;
  assign out_pattern = pat;
  assign out_sum     = sum + SUM_W'(rd_bit && ctrl.op == OP_CLASSIFY);

endmodule

### design/rwc_tally.sv
// class match counters and running winner search at the end of the chain
// depends on rwc_pkg
`timescale 1ns / 1ps

module rwc_tally #(
  parameter int CLASSES    = 4,
  parameter int COUNT_BITS = 16,
  parameter int SUM_W      = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  input  rwc_pkg::tok_ctrl_t              in_ctrl,
  input  logic [$clog2(CLASSES)-1:0]      in_class,
  input  logic [SUM_W-1:0]                in_sum,
  output logic                            res_valid,
  output logic [rwc_pkg::CLASS_OUT_W-1:0] res_class,
  output logic [rwc_pkg::SCORE_W-1:0]     res_score
);
  import rwc_pkg::*;

  localparam int CLS_W = $clog2(CLASSES);
  localparam int WIDE  = COUNT_BITS > SCORE_W ? COUNT_BITS : SCORE_W;
  localparam int CW    = CLS_W > CLASS_OUT_W ? CLS_W : CLASS_OUT_W;
  localparam logic [COUNT_BITS:0] COUNT_MAX = {1'b0, {COUNT_BITS{1'b1}}};

  logic [COUNT_BITS-1:0] counts [CLASSES];
  logic [COUNT_BITS-1:0] best;
  logic [CLS_W-1:0]      best_cls;
  logic [COUNT_BITS:0]   add;
  logic [COUNT_BITS-1:0] sat;
  logic                  upd;
  logic                  better;
  logic [COUNT_BITS-1:0] win_val;
  logic [CLS_W-1:0]      win_cls;
  logic [WIDE-1:0]       win_wide;
  logic [CW-1:0]         win_cls_wide;

  // saturating add of the chain count and compare against the running best
  always_comb begin
    upd      = in_ctrl.valid && in_ctrl.op == OP_CLASSIFY;
    add      = {1'b0, counts[in_class]} + (COUNT_BITS+1)'(in_sum);
    sat      = (add > COUNT_MAX) ? COUNT_MAX[COUNT_BITS-1:0] : add[COUNT_BITS-1:0];
    better   = (in_class == '0) || (sat > best);
    win_val  = better ? sat : best;
    win_cls  = better ? in_class : best_cls;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CLASSES; c++) begin
        counts[c] <= '0;
      end
      res_valid <= 1'b0;
    end else begin
      res_valid <= upd && in_ctrl.last && in_ctrl.final_class;
      if (upd) begin
        counts[in_class] <= in_ctrl.last ? '0 : sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      best     <= win_val;
      best_cls <= win_cls;
    end
  end

  // clamp the score, keep the low bits of the class
  always_comb begin
    win_wide     = WIDE'(win_val);
    win_cls_wide = CW'(win_cls);
  end

  always_ff @(posedge clk) begin
    res_score <= (win_wide > WIDE'(SCORE_MAX)) ? SCORE_MAX : win_wide[SCORE_W-1:0];
    res_class <= win_cls_wide[CLASS_OUT_W-1:0];
  end

endmodule

### design/ram_weightless_classifier_core.sv
// channel | dir | handshake           | fields
// in      | in  | in_valid, in_stall  | cmd, class_index, pattern, last_pattern
// out     | out | out_valid, out_stall| winner_class, winner_score
//
// a classify word sends one token per class, a train word a single token, from the sequencer
// down the chain of NEURONS cells; the last token passes each cell register and the
// tally register before its result enters the queue. after reset the bit banks are
// swept clear, all CLASSES * 2^ADDRESS_BITS addresses, while in_stall stays high.
// a two-word result queue lets input go on under out_stall while queued plus in-flight results number under two.
// depends on rwc_pkg, rwc_cell, rwc_tally and the defines header
`timescale 1ns / 1ps
`include "ram_weightless_classifier_core_defines.svh"

module ram_weightless_classifier_core #(
  parameter int CLASSES      = 4,
  parameter int NEURONS      = 8,
  parameter int ADDRESS_BITS = 8,
  parameter int COUNT_BITS   = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            cmd,
  input  logic [1:0]                      class_index,
  input  logic [rwc_pkg::PATTERN_W-1:0]   pattern,
  input  logic                            last_pattern,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [rwc_pkg::CLASS_OUT_W-1:0] winner_class,
  output logic [rwc_pkg::SCORE_W-1:0]     winner_score
);
  import rwc_pkg::*;

  localparam int CLS_W    = $clog2(CLASSES);
  localparam int SUM_W    = $clog2(NEURONS + 1);
  localparam int RAM_AW   = CLS_W + ADDRESS_BITS;
  localparam int CIW      = CLS_W > 2 ? CLS_W : 2;
  localparam logic [RAM_AW-1:0] CLR_LAST = RAM_AW'((CLASSES << ADDRESS_BITS) - 1);
  localparam logic [CLS_W-1:0]  CLS_LAST = CLS_W'(CLASSES - 1);

  state_e               state, state_next;
  logic [RAM_AW-1:0]    clr_addr;
  logic [CLS_W-1:0]     cls_cnt;
  op_e                  item_op;
  logic [CLS_W-1:0]     item_class;
  logic                 item_ok;
  logic                 item_last;
  logic [PATTERN_W-1:0] item_pattern;
  logic [CIW-1:0]       class_wide;
  logic                 issue_done;
  logic                 credit_ok;
  logic                 in_acc;
  logic                 res_item;
  logic                 clr_en;
  logic [1:0]           inflight;
  logic [1:0]           q_count;
  logic                 q_wr;
  logic                 q_rd;
  logic [CLASS_OUT_W-1:0] q_class [2];
  logic [SCORE_W-1:0]   q_score [2];
  logic                 push;
  logic                 pop;
  logic [CLASS_OUT_W-1:0] res_class;
  logic [SCORE_W-1:0]   res_score;

  tok_ctrl_t            chain_ctrl    [NEURONS+1];
  logic [CLS_W-1:0]     chain_class   [NEURONS+1];
  logic [SUM_W-1:0]     chain_sum     [NEURONS+1];
  logic [PATTERN_W-1:0] chain_pattern [NEURONS];

  // handshake helpers
  assign issue_done = (item_op == OP_TRAIN) || (cls_cnt == CLS_LAST);
  assign credit_ok  = ({1'b0, q_count} + {1'b0, inflight}) < 3'd2;
  assign in_acc     = in_valid && !in_stall;
  assign res_item   = cmd && last_pattern;
  assign class_wide = CIW'(class_index);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr_addr == CLR_LAST) state_next = ST_IDLE;
      ST_IDLE:  if (in_acc) state_next = ST_ISSUE;
      ST_ISSUE: if (issue_done && !in_acc) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  // sequencer outputs: stall, clear enable, token into the first cell
  always_comb begin
    in_stall = 1'b1;
    clr_en   = 1'b0;
    chain_ctrl[0]  = '0;
    chain_ctrl[0].op          = item_op;
    chain_ctrl[0].last        = item_last;
    chain_ctrl[0].final_class = (cls_cnt == CLS_LAST);
    case (state)
      ST_CLEAR: clr_en = 1'b1;
      ST_IDLE:  in_stall = !credit_ok;
      ST_ISSUE: begin
        in_stall = !(issue_done && credit_ok);
        chain_ctrl[0].valid = (item_op == OP_CLASSIFY) || item_ok;
      end
      default:  in_stall = 1'b1;
    endcase
    chain_class[0]   = (item_op == OP_TRAIN) ? item_class : cls_cnt;
    chain_sum[0]     = '0;
    chain_pattern[0] = item_pattern;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      cls_cnt  <= '0;
      inflight <= 2'd0;
    end else begin
      state <= state_next;
      if (clr_en) clr_addr <= clr_addr + 1'b1;
      if (in_acc) begin
        cls_cnt <= '0;
      end else if (state == ST_ISSUE && !issue_done) begin
        cls_cnt <= cls_cnt + 1'b1;
      end
      inflight <= inflight + 2'(in_acc && res_item) - 2'(push);
    end
  end

  // latch the accepted word
  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_op      <= op_e'(cmd);
      item_class   <= class_wide[CLS_W-1:0];
      item_ok      <= 32'(class_index) < 32'(CLASSES);
      item_last    <= last_pattern;
      item_pattern <= pattern;
    end
  end

  // chain of neuron cells
  for (genvar j = 0; j < NEURONS; j++) begin : g_cell
    if (j < NEURONS - 1) begin : g_mid
      rwc_cell #(
        .NEURON_IDX(j), .CLASSES(CLASSES), .ADDRESS_BITS(ADDRESS_BITS), .SUM_W(SUM_W)
      ) u_cell (
        .clk, .rst, .clr_en, .clr_addr,
        .in_ctrl(chain_ctrl[j]), .in_class(chain_class[j]),
        .in_pattern(chain_pattern[j]), .in_sum(chain_sum[j]),
        .out_ctrl(chain_ctrl[j+1]), .out_class(chain_class[j+1]),
        .out_pattern(chain_pattern[j+1]), .out_sum(chain_sum[j+1])
      );
    end else begin : g_end
      rwc_cell #(
        .NEURON_IDX(j), .CLASSES(CLASSES), .ADDRESS_BITS(ADDRESS_BITS), .SUM_W(SUM_W)
      ) u_cell (
        .clk, .rst, .clr_en, .clr_addr,
        .in_ctrl(chain_ctrl[j]), .in_class(chain_class[j]),
        .in_pattern(chain_pattern[j]), .in_sum(chain_sum[j]),
        .out_ctrl(chain_ctrl[j+1]), .out_class(chain_class[j+1]),
        .out_pattern(), .out_sum(chain_sum[j+1])
      );
    end
  end

  // per-class counters and winner
  rwc_tally #(
    .CLASSES(CLASSES), .COUNT_BITS(COUNT_BITS), .SUM_W(SUM_W)
  ) u_tally (
    .clk, .rst,
    .in_ctrl(chain_ctrl[NEURONS]), .in_class(chain_class[NEURONS]),
    .in_sum(chain_sum[NEURONS]),
    .res_valid(push), .res_class, .res_score
  );

  // two-word result queue
  assign pop          = out_valid && !out_stall;
  assign out_valid    = q_count != 2'd0;
  assign winner_class = q_class[q_rd];
  assign winner_score = q_score[q_rd];

  always_ff @(posedge clk) begin
    if (rst) begin
      q_count <= 2'd0;
      q_wr    <= 1'b0;
      q_rd    <= 1'b0;
    end else begin
      q_count <= q_count + 2'(push) - 2'(pop);
      if (push) q_wr <= !q_wr;
      if (pop)  q_rd <= !q_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_class[q_wr] <= res_class;
      q_score[q_wr] <= res_score;
    end
  end

  // checks
  `RWC_NEVER(a_queue_overrun, push && q_count == 2'd2, "result pushed into full queue")
  `RWC_NEVER(a_credit_bound, ({1'b0, q_count} + {1'b0, inflight}) > 3'd2, "result credit exceeded")
  `RWC_IMPLY(a_no_accept_clear, state == ST_CLEAR, in_stall, "word taken during clear sweep")
  `RWC_IMPLY_NEXT(a_accept_issues, in_acc, state == ST_ISSUE, "accepted word not issued")

endmodule
